### sv/kilp_pkg.sv
// types, constants and helper functions for the keyed integer list parser
// no dependencies
package kilp_pkg;

    typedef enum logic [10:0] {
        PH_BRACE   = 11'b000_0000_0001,
        PH_QUOTE   = 11'b000_0000_0010,
        PH_KEY     = 11'b000_0000_0100,
        PH_COLON   = 11'b000_0000_1000,
        PH_BRACKET = 11'b000_0001_0000,
        PH_ELEM    = 11'b000_0010_0000,
        PH_SIGN    = 11'b000_0100_0000,
        PH_DIGITS  = 11'b000_1000_0000,
        PH_TAIL    = 11'b001_0000_0000,
        PH_AFTER   = 11'b010_0000_0000,
        PH_DONE    = 11'b100_0000_0000
    } phase_t;

    localparam logic [1:0] ST_VALUE = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_KEY   = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    localparam logic [2:0] KEY_LEN = 3'd4;
    localparam logic [2:0] KEY_POS_MAX = 3'd7;

    // expected key letters
    function automatic logic [7:0] want_key(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h44;
            2'd1:    ch = 8'h41;
            2'd2:    ch = 8'h54;
            default: ch = 8'h41;
        endcase
        return ch;
    endfunction

    // times ten plus digit, saturating at 2^31
    function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] sum;
        sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d};
        return (sum > 36'h0_8000_0000) ? 32'h8000_0000 : sum[31:0];
    endfunction

    // signed saturation, zero low half replaced by one
    function automatic logic [31:0] finished_value(input logic [31:0] acc, input logic neg);
        logic [31:0] v;
        if (neg)
        begin
            v = (acc >= 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - acc);
        end
        else
        begin
            v = (acc >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
        end
        if (v[15:0] == 16'd0)
        begin
            v = 32'd1;
        end
        return v;
    endfunction

endpackage

### sv/keyed_integer_list_parser.sv
// keyed integer list parser: byte stream in, parsed integers and end, key-error and error codes out
// depends on kilp_pkg
// an accepted word goes through the input register, then the result register, to the master side
// throughput: one word per cycle while the master side does not stall; the parse step
// between the input register and the result register is combinational
// reset: rst_n asynchronous active low, clears both registers' valid flags and
// returns the parser to waiting for the opening brace
module keyed_integer_list_parser
    import kilp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast    // last
);

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [7:0]  in_char_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic [2:0]  key_pos_reg, key_pos_next;
    logic        key_bad_reg, key_bad_next;

    logic        res_valid;
    logic [1:0]  res_status;
    logic [31:0] res_value;
    logic        res_last;

    logic        advance;
    logic        out_free;
    logic [7:0]  c;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [31:0] acc_digit;
    logic [31:0] fin_value;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign c         = in_char_reg;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space  = (c == CH_SPACE);
    assign digit     = 4'(c - CH_ZERO);
    assign acc_digit = add_digit(acc_reg, digit);
    assign fin_value = finished_value(acc_reg, neg_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        seen_next    = seen_reg;
        key_pos_next = key_pos_reg;
        key_bad_next = key_bad_reg;
        res_valid    = 1'b0;
        res_status   = ST_ERROR;
        res_value    = 32'd0;
        res_last     = 1'b1;
        if (in_kind_reg)
        begin
            phase_next   = PH_BRACE;
            acc_next     = 32'd0;
            neg_next     = 1'b0;
            seen_next    = 1'b0;
            key_pos_next = 3'd0;
            key_bad_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_BRACE:
                begin
                    if (c == CH_LBRACE)
                        phase_next = PH_QUOTE;
                    else if (!is_space)
                        res_valid = 1'b1;
                end
                PH_QUOTE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        key_pos_next = 3'd0;
                        key_bad_next = 1'b0;
                        phase_next   = PH_KEY;
                    end
                    else if (!is_space)
                        res_valid = 1'b1;
                end
                PH_KEY:
                begin
                    if (c == CH_QUOTE)
                    begin
                        if (key_bad_reg || key_pos_reg != KEY_LEN)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_KEY;
                        end
                        else
                            phase_next = PH_COLON;
                    end
                    else
                    begin
                        if (key_pos_reg >= KEY_LEN || c != want_key(key_pos_reg[1:0]))
                            key_bad_next = 1'b1;
                        if (key_pos_reg < KEY_POS_MAX)
                            key_pos_next = key_pos_reg + 3'd1;
                    end
                end
                PH_COLON:
                begin
                    if (c == CH_COLON)
                        phase_next = PH_BRACKET;
                    else if (!is_space)
                        res_valid = 1'b1;
                end
                PH_BRACKET:
                begin
                    if (c == CH_LBRACK)
                        phase_next = PH_ELEM;
                    else if (!is_space)
                        res_valid = 1'b1;
                end
                PH_ELEM:
                begin
                    if (!is_space)
                    begin
                        acc_next  = 32'd0;
                        neg_next  = 1'b0;
                        seen_next = 1'b0;
                        if (c == CH_MINUS || c == CH_PLUS)
                        begin
                            neg_next   = (c == CH_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = add_digit(32'd0, digit);
                            seen_next  = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else if (c == CH_RBRACK)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_END;
                        end
                        else
                            res_valid = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_digit;
                        seen_next  = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                        res_valid = 1'b1;
                end
                PH_DIGITS:
                begin
                    res_valid = 1'b1;
                    if (is_digit)
                    begin
                        acc_next  = acc_digit;
                        seen_next = 1'b1;
                        res_valid = 1'b0;
                    end
                    else if (c == CH_RBRACK)
                    begin
                        res_status = ST_VALUE;
                        res_value  = fin_value;
                    end
                    else if (c == CH_DOT || c == CH_E || c == CH_MINUS || is_space
                             || c == CH_COMMA)
                    begin
                        res_status = ST_VALUE;
                        res_value  = fin_value;
                        res_last   = 1'b0;
                        if (is_space)
                            phase_next = PH_AFTER;
                        else if (c == CH_COMMA)
                            phase_next = PH_ELEM;
                        else
                            phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    if (is_space)
                        phase_next = PH_AFTER;
                    else if (c == CH_COMMA)
                        phase_next = PH_ELEM;
                    else if (c == CH_RBRACK)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_END;
                    end
                    else if (!(is_digit || c == CH_DOT || c == CH_E || c == CH_MINUS))
                        res_valid = 1'b1;
                end
                PH_AFTER:
                begin
                    if (c == CH_COMMA)
                        phase_next = PH_ELEM;
                    else if (c == CH_RBRACK)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_END;
                    end
                    else if (!is_space)
                        res_valid = 1'b1;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            if (res_valid && res_last)
                phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_BRACE;
            acc_reg       <= 32'd0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            key_pos_reg   <= 3'd0;
            key_bad_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                neg_reg     <= neg_next;
                seen_reg    <= seen_next;
                key_pos_reg <= key_pos_next;
                key_bad_reg <= key_bad_next;
            end
            if (out_free)
                out_valid_reg <= advance && res_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // finishing result parks the parser
    a_last_parks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res_last |=> phase_reg == PH_DONE)
        else $error("parser not parked after finishing result");

    // finished parser stays silent
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_DONE |-> !res_valid)
        else $error("result produced after document end");

    // only value results carry data
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_VALUE |-> m_tdata == 32'd0)
        else $error("non-value result carries data");

    // value results never have a zero low half
    a_low_half: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_VALUE |-> m_tdata[15:0] != 16'd0)
        else $error("value result with zero low half");

    // a digit sequence always has a digit behind it
    a_digits_seen: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIGITS || phase_reg == PH_TAIL |-> seen_reg)
        else $error("digit phase without a digit");

endmodule
